// File: src/stpu_pkg.sv
// Shared types and constants for the segment table protection unit.
package stpu_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 32;
  localparam int CMD_W     = 3;
  localparam int FLAGS_W   = 3;
  localparam int STATUS_W  = 2;
  localparam int OFF_W     = 12;
  localparam int IDX_W     = ADDR_W - OFF_W;
  localparam int SEG_IDX_W = 6;
  localparam int SEG_WORDS = 1 << OFF_W;
  localparam int SIZE_W    = OFF_W + 1;
  localparam int GRP_SIZE  = 8;
  localparam int GRP_BIT_W = 3;

  localparam int PERM_READ   = 0;
  localparam int PERM_WRITE  = 1;
  localparam int PERM_MAPPED = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_ALLOC  = 3'd2,
    CMD_RESIZE = 3'd3,
    CMD_PERM   = 3'd4,
    CMD_FREE   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_PROT    = 2'd2,
    ST_OOM     = 2'd3
  } status_t;

  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_EXEC = 1'b1
  } state_t;

  // One descriptor as it sits in the table memory.
  typedef struct packed {
    logic               in_use;
    logic [SIZE_W-1:0]  size;
    logic [FLAGS_W-1:0] mode;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Updates to the free-slot map and the high-water mark.
  typedef struct packed {
    logic take;
    logic release_slot;
    logic append;
  } alloc_op_t;

endpackage

// File: src/stpu_in_if.sv
// Command channel: one beat carries one command.
interface stpu_in_if;
  logic                          valid;
  logic                          ready;
  logic [stpu_pkg::CMD_W-1:0]    command;
  logic [stpu_pkg::ADDR_W-1:0]   address;
  logic [stpu_pkg::LEN_W-1:0]    length;
  logic [stpu_pkg::FLAGS_W-1:0]  flags;

  modport source (output valid, command, address, length, flags, input ready);
  modport sink   (input valid, command, address, length, flags, output ready);
endinterface

// File: src/stpu_out_if.sv
// Result channel: one beat carries the answer to one command.
interface stpu_out_if;
  logic                            valid;
  logic                            ready;
  logic [stpu_pkg::STATUS_W-1:0]   status;
  logic [stpu_pkg::SEG_IDX_W-1:0]  segment_index;
  logic [stpu_pkg::OFF_W-1:0]      word_offset;
  logic [stpu_pkg::ADDR_W-1:0]     result_address;

  modport source (output valid, status, segment_index, word_offset, result_address,
                  input ready);
  modport sink   (input valid, status, segment_index, word_offset, result_address,
                  output ready);
endinterface

// File: src/stpu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stpu_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// File: src/stpu_alloc.sv
// Free-slot map, high-water mark and two-level first-free search.
module stpu_alloc #(
  parameter int MAX_SEGMENTS = 64,
  localparam int AW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int MW     = $clog2(MAX_SEGMENTS + 1),
  localparam int GRPS   = (MAX_SEGMENTS + stpu_pkg::GRP_SIZE - 1) / stpu_pkg::GRP_SIZE,
  localparam int GW     = (GRPS > 1) ? $clog2(GRPS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stpu_pkg::alloc_op_t op,
  input  logic [AW-1:0]       slot_idx,
  output logic [MW-1:0]       mark,
  output logic                free_found,
  output logic [AW-1:0]       free_slot
);

  localparam int PAD_W = GRPS * stpu_pkg::GRP_SIZE;

  // A set bit marks a slot below the high-water mark that is not in use.
  logic [MAX_SEGMENTS-1:0]         free_map_r, free_map_nxt;
  logic [MW-1:0]                   mark_r, mark_nxt;
  logic [GW-1:0]                   grp_r;
  logic                            grp_found_r;
  logic [PAD_W-1:0]                map_pad;
  logic [GRPS-1:0]                 grp_any;
  logic [GW-1:0]                   grp_sel;
  logic                            grp_hit;
  logic [stpu_pkg::GRP_SIZE-1:0]   grp_bits;
  logic [stpu_pkg::GRP_BIT_W-1:0]  bit_sel;
  logic [GW+stpu_pkg::GRP_BIT_W-1:0] slot_wide;

  for (genvar b = 0; b < PAD_W; b++) begin : g_pad
    if (b < MAX_SEGMENTS) begin : g_real
      assign map_pad[b] = free_map_r[b];
    end else begin : g_fill
      assign map_pad[b] = 1'b0;
    end
  end

  for (genvar g = 0; g < GRPS; g++) begin : g_any
    assign grp_any[g] = |map_pad[g*stpu_pkg::GRP_SIZE +: stpu_pkg::GRP_SIZE];
  end

  always_comb begin
    free_map_nxt = free_map_r;
    if (op.take) begin
      free_map_nxt[slot_idx] = 1'b0;
    end
    if (op.release_slot) begin
      free_map_nxt[slot_idx] = 1'b1;
    end
    mark_nxt = mark_r + MW'(op.append);
  end

  // First stage: lowest group holding a free slot, registered every cycle.
  always_comb begin
    grp_sel = '0;
    grp_hit = 1'b0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GW'(g);
        grp_hit = 1'b1;
      end
    end
  end

  // Second stage: lowest free slot inside the registered group.
  always_comb begin
    grp_bits = '0;
    for (int g = 0; g < GRPS; g++) begin
      if (grp_r == GW'(g)) begin
        grp_bits = map_pad[g*stpu_pkg::GRP_SIZE +: stpu_pkg::GRP_SIZE];
      end
    end
    bit_sel = '0;
    for (int b = stpu_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = stpu_pkg::GRP_BIT_W'(b);
      end
    end
    slot_wide = {grp_r, bit_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r  <= '0;
      mark_r      <= '0;
      grp_found_r <= 1'b0;
    end else begin
      free_map_r  <= free_map_nxt;
      mark_r      <= mark_nxt;
      grp_found_r <= grp_hit;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_sel;
  end

  assign mark       = mark_r;
  assign free_found = grp_found_r;
  assign free_slot  = slot_wide[AW-1:0];

endmodule

// File: src/segment_table_protection_unit.sv
// Segment table protection unit: descriptor table, access checks and allocation.
// The command and its descriptor read are registered on acceptance; the answer is registered in
// the output register when the execute state commits. A new command is taken only once the
// previous one has been checked and its descriptor written back.
// A held result stalls the execute cycle; one more command is taken while a result waits.
// Reset (synchronous, active low) clears the high-water mark, free-slot map and register.
module segment_table_protection_unit #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  stpu_in_if.sink           in_ch,
  stpu_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int MW = $clog2(MAX_SEGMENTS + 1);

  // Control state.
  stpu_pkg::state_t state_r, state_nxt;
  logic             out_valid_r;
  logic             chk_rd_perm_r;

  // Latched command.
  logic [stpu_pkg::CMD_W-1:0]   cmd_r;
  logic [stpu_pkg::ADDR_W-1:0]  addr_r;
  logic [stpu_pkg::LEN_W-1:0]   len_r;
  logic [stpu_pkg::FLAGS_W-1:0] flg_r;

  // Result registers that feed the output channel.
  logic [stpu_pkg::STATUS_W-1:0]  out_status_r;
  logic [stpu_pkg::SEG_IDX_W-1:0] out_idx_r;
  logic [stpu_pkg::OFF_W-1:0]     out_off_r;
  logic [stpu_pkg::ADDR_W-1:0]    out_raddr_r;

  logic in_ready;
  logic in_fire;
  logic go;

  // Descriptor memory and allocator hookup.
  logic [stpu_pkg::IDX_W-1:0] rd_idx;
  logic [AW-1:0]              ram_raddr;
  logic                       ram_we_req;
  logic [AW-1:0]              ram_waddr;
  stpu_pkg::entry_t           ram_wdata;
  logic [stpu_pkg::ENTRY_W-1:0] ram_rdata;
  stpu_pkg::entry_t           ent;

  stpu_pkg::alloc_op_t alloc_req;
  stpu_pkg::alloc_op_t alloc_op;
  logic [AW-1:0]       alloc_slot;
  logic [MW-1:0]       mark;
  logic                free_found;
  logic [AW-1:0]       free_slot;

  // Datapath of the execute cycle.
  logic [stpu_pkg::IDX_W-1:0]     idx_w;
  logic [stpu_pkg::OFF_W-1:0]     off_w;
  logic                           in_range;
  logic                           slot_ok;
  logic [stpu_pkg::LEN_W:0]       run_end;
  logic                           len_too_big;
  logic [AW-1:0]                  new_slot;
  logic [stpu_pkg::STATUS_W-1:0]  res_status;
  logic [stpu_pkg::SEG_IDX_W-1:0] res_idx;
  logic [stpu_pkg::OFF_W-1:0]     res_off;
  logic [stpu_pkg::ADDR_W-1:0]    res_raddr;

  // The control FSM has two states. IDLE takes a command and starts the
  // descriptor read; EXEC has the read data, decides the answer and writes
  // the descriptor back, but only once the output register can take the
  // result, so nothing is committed twice or lost.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stpu_pkg::STATE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    go        = 1'b0;
    unique case (state_r)
      stpu_pkg::STATE_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = stpu_pkg::STATE_EXEC;
        end
      end
      stpu_pkg::STATE_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          go        = 1'b1;
          state_nxt = stpu_pkg::STATE_IDLE;
        end
      end
      default: begin
        state_nxt = stpu_pkg::STATE_IDLE;
      end
    endcase
  end

  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.command;
      addr_r <= in_ch.address;
      len_r  <= in_ch.length;
      flg_r  <= in_ch.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_rd_perm_r <= 1'b0;
    end else if (cfg_wr_en) begin
      chk_rd_perm_r <= cfg_wr_data;
    end
  end

  // The read address follows the incoming command while idle and holds the
  // latched one afterwards, so the read data stays put during a stall. A
  // write-back lands before the next command's read is issued, so no
  // forwarding is needed between consecutive commands.
  assign rd_idx    = (state_r == stpu_pkg::STATE_IDLE)
                     ? in_ch.address[stpu_pkg::ADDR_W-1:stpu_pkg::OFF_W]
                     : addr_r[stpu_pkg::ADDR_W-1:stpu_pkg::OFF_W];
  assign ram_raddr = rd_idx[AW-1:0];

  stpu_ram #(
    .WIDTH (stpu_pkg::ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_desc_ram (
    .clk       (clk),
    .wr_en     (ram_we_req && go),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr   (ram_raddr),
    .rd_data_r (ram_rdata)
  );

  assign ent = stpu_pkg::entry_t'(ram_rdata);

  // Entries at or above the high-water mark were never written; every
  // command tests the index against the mark before using the read data.
  assign alloc_op.take         = alloc_req.take && go;
  assign alloc_op.release_slot = alloc_req.release_slot && go;
  assign alloc_op.append       = alloc_req.append && go;

  stpu_alloc #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (alloc_op),
    .slot_idx   (alloc_slot),
    .mark       (mark),
    .free_found (free_found),
    .free_slot  (free_slot)
  );

  assign idx_w       = addr_r[stpu_pkg::ADDR_W-1:stpu_pkg::OFF_W];
  assign off_w       = addr_r[stpu_pkg::OFF_W-1:0];
  assign in_range    = stpu_pkg::IDX_W'(mark) > idx_w;
  assign slot_ok     = in_range && ent.in_use;
  assign run_end     = {1'b0, len_r} + (stpu_pkg::LEN_W+1)'(off_w);
  assign len_too_big = len_r > stpu_pkg::LEN_W'(stpu_pkg::SEG_WORDS);
  assign new_slot    = free_found ? free_slot : mark[AW-1:0];

  // Command decode and checks. Each arm tests in the order that decides
  // which fault wins when several apply.
  always_comb begin
    res_status = stpu_pkg::ST_OK;
    res_idx    = idx_w[stpu_pkg::SEG_IDX_W-1:0];
    res_off    = off_w;
    res_raddr  = '0;
    ram_we_req = 1'b0;
    ram_waddr  = idx_w[AW-1:0];
    ram_wdata  = ent;
    alloc_req  = '0;
    alloc_slot = idx_w[AW-1:0];

    unique case (cmd_r) inside
      stpu_pkg::CMD_READ, stpu_pkg::CMD_WRITE: begin
        if (!in_range) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (stpu_pkg::SIZE_W'(off_w) >= ent.size) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (len_r > stpu_pkg::LEN_W'(ent.size)) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (run_end > (stpu_pkg::LEN_W+1)'(ent.size)) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (chk_rd_perm_r && !ent.mode[stpu_pkg::PERM_READ]) begin
          res_status = stpu_pkg::ST_PROT;
        end else if ((cmd_r == stpu_pkg::CMD_WRITE) && !ent.mode[stpu_pkg::PERM_WRITE]) begin
          res_status = stpu_pkg::ST_PROT;
        end
      end
      stpu_pkg::CMD_ALLOC: begin
        res_off = '0;
        if (len_too_big) begin
          res_status = stpu_pkg::ST_OOM;
          res_idx    = '0;
        end else if (!free_found && (mark == MW'(MAX_SEGMENTS))) begin
          res_status = stpu_pkg::ST_OOM;
          res_idx    = '0;
        end else begin
          // Reuse the lowest freed slot, otherwise open a new one at the mark.
          alloc_req.take   = free_found;
          alloc_req.append = !free_found;
          alloc_slot       = new_slot;
          ram_we_req       = 1'b1;
          ram_waddr        = new_slot;
          ram_wdata.in_use = 1'b1;
          ram_wdata.size   = len_r[stpu_pkg::SIZE_W-1:0];
          ram_wdata.mode   = flg_r;
          res_idx          = stpu_pkg::SEG_IDX_W'(new_slot);
          res_raddr        = {stpu_pkg::IDX_W'(new_slot), {stpu_pkg::OFF_W{1'b0}}};
        end
      end
      stpu_pkg::CMD_RESIZE: begin
        if (len_too_big) begin
          res_status = stpu_pkg::ST_OOM;
        end else if (!slot_ok) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (ent.mode[stpu_pkg::PERM_MAPPED] || !ent.mode[stpu_pkg::PERM_WRITE]) begin
          res_status = stpu_pkg::ST_PROT;
        end else begin
          ram_we_req     = 1'b1;
          ram_wdata.size = len_r[stpu_pkg::SIZE_W-1:0];
          res_raddr      = addr_r;
        end
      end
      stpu_pkg::CMD_PERM: begin
        if (!slot_ok) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (ent.mode[stpu_pkg::PERM_MAPPED] || flg_r[stpu_pkg::PERM_MAPPED]
                     || !flg_r[stpu_pkg::PERM_READ]) begin
          res_status = stpu_pkg::ST_PROT;
        end else begin
          ram_we_req     = 1'b1;
          ram_wdata.mode = flg_r;
        end
      end
      stpu_pkg::CMD_FREE: begin
        if (!slot_ok) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else begin
          // The mark never shrinks; the slot goes back to the free map.
          ram_we_req             = 1'b1;
          ram_wdata              = '0;
          alloc_req.release_slot = 1'b1;
        end
      end
      default: begin
        // Undefined command codes change nothing and report the address split.
      end
    endcase
  end

  // Output register: loaded on the commit cycle, emptied when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_off_r    <= res_off;
      out_raddr_r  <= res_raddr;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.segment_index  = out_idx_r;
  assign out_ch.word_offset    = out_off_r;
  assign out_ch.result_address = out_raddr_r;

endmodule

// File: sim/stpu_answer_check.sv
// Answer checker for the segment table: predicts every result beat and compares it field by field.
`timescale 1ns / 1ps
module stpu_answer_check (
  input  logic clk,
  input  logic rst_n,
  stpu_in_if   cmd_bus,
  stpu_out_if  ans_bus,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   mismatches,
  output int   answers_due_count,
  output int   count_ok,
  output int   count_outside,
  output int   count_prot,
  output int   count_oom
);
  import stpu_pkg::*;

  localparam int TABLE_DEPTH = 64;

  typedef struct packed {
    status_t               status;
    logic [SEG_IDX_W-1:0]  segment;
    logic [OFF_W-1:0]      offset;
    logic [ADDR_W-1:0]     base;
  } answer_t;

  // Shadow copy of the descriptor table and the read-permission setting.
  logic               seg_live  [TABLE_DEPTH];
  logic [SIZE_W-1:0]  seg_words [TABLE_DEPTH];
  logic [FLAGS_W-1:0] seg_mode  [TABLE_DEPTH];
  logic [6:0]         high_water;
  logic               need_read_perm;

  answer_t answers_due [$];

  function automatic status_t access_status(logic [IDX_W-1:0] slot_full,
                                            logic [OFF_W-1:0] off,
                                            logic [LEN_W-1:0] len, logic is_write);
    logic [SIZE_W-1:0]    words;
    logic [FLAGS_W-1:0]   mode;
    logic [SEG_IDX_W-1:0] slot;
    if (slot_full >= high_water) return ST_OUTSIDE;
    slot  = slot_full[SEG_IDX_W-1:0];
    words = seg_words[slot];
    mode  = seg_mode[slot];
    if (off >= words) return ST_OUTSIDE;
    if (len > words) return ST_OUTSIDE;
    if (({1'b0, len} + off) > words) return ST_OUTSIDE;
    if (need_read_perm && !mode[PERM_READ]) return ST_PROT;
    if (is_write && !mode[PERM_WRITE]) return ST_PROT;
    return ST_OK;
  endfunction

  // Works out the answer to one command and applies its effect on the table.
  function automatic answer_t predict_answer(logic [CMD_W-1:0] op, logic [ADDR_W-1:0] addr,
                                             logic [LEN_W-1:0] len,
                                             logic [FLAGS_W-1:0] perm);
    answer_t              ans;
    logic [IDX_W-1:0]     slot_full;
    logic [SEG_IDX_W-1:0] slot;
    logic                 live;
    int                   free_slot;
    int                   i;
    slot_full   = addr[ADDR_W-1:OFF_W];
    slot        = slot_full[SEG_IDX_W-1:0];
    ans.status  = ST_OK;
    ans.segment = slot;
    ans.offset  = addr[OFF_W-1:0];
    ans.base    = '0;
    live        = 1'b0;
    if (slot_full < high_water) live = seg_live[slot];
    case (op)
      CMD_READ, CMD_WRITE: begin
        ans.status = access_status(slot_full, addr[OFF_W-1:0], len, op == CMD_WRITE);
      end
      CMD_ALLOC: begin
        ans.offset  = '0;
        ans.segment = '0;
        if (len > SEG_WORDS) begin
          ans.status = ST_OOM;
        end else begin
          free_slot = -1;
          for (i = 0; i < high_water; i++) begin
            if (!seg_live[i] && free_slot < 0) free_slot = i;
          end
          if (free_slot < 0 && high_water < TABLE_DEPTH) begin
            free_slot  = int'(high_water);
            high_water = high_water + 7'd1;
          end
          if (free_slot < 0) begin
            ans.status = ST_OOM;
          end else begin
            seg_live[free_slot]  = 1'b1;
            seg_words[free_slot] = len[SIZE_W-1:0];
            seg_mode[free_slot]  = perm;
            ans.segment          = free_slot[SEG_IDX_W-1:0];
            ans.base             = free_slot * SEG_WORDS;
          end
        end
      end
      CMD_RESIZE: begin
        if (len > SEG_WORDS) ans.status = ST_OOM;
        else if (!live) ans.status = ST_OUTSIDE;
        else if (seg_mode[slot][PERM_MAPPED]) ans.status = ST_PROT;
        else if (!seg_mode[slot][PERM_WRITE]) ans.status = ST_PROT;
        else begin
          seg_words[slot] = len[SIZE_W-1:0];
          ans.base        = addr;
        end
      end
      CMD_PERM: begin
        if (!live) ans.status = ST_OUTSIDE;
        else if (seg_mode[slot][PERM_MAPPED]) ans.status = ST_PROT;
        else if (perm[PERM_MAPPED]) ans.status = ST_PROT;
        else if (!perm[PERM_READ]) ans.status = ST_PROT;
        else seg_mode[slot] = perm;
      end
      CMD_FREE: begin
        if (!live) ans.status = ST_OUTSIDE;
        else begin
          seg_live[slot]  = 1'b0;
          seg_words[slot] = '0;
          seg_mode[slot]  = '0;
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  initial begin
    mismatches        = 0;
    answers_due_count = 0;
    count_ok          = 0;
    count_outside     = 0;
    count_prot        = 0;
    count_oom         = 0;
  end

  always @(posedge clk) begin
    answer_t due;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        seg_live[i]  = 1'b0;
        seg_words[i] = '0;
        seg_mode[i]  = '0;
      end
      high_water     = '0;
      need_read_perm = 1'b0;
      answers_due.delete();
    end else begin
      if (cfg_wr_en) need_read_perm = cfg_wr_data;
      // The oldest expectation is retired before this edge's command is predicted.
      if (ans_bus.valid && ans_bus.ready) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no command outstanding: status %0d segment_index %0d",
                 ans_bus.status, ans_bus.segment_index);
          mismatches++;
        end else begin
          due = answers_due.pop_front();
          if (ans_bus.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, ans_bus.status);
            mismatches++;
          end
          if (ans_bus.segment_index !== due.segment) begin
            $error("segment_index: expected %0d, got %0d", due.segment, ans_bus.segment_index);
            mismatches++;
          end
          if (ans_bus.word_offset !== due.offset) begin
            $error("word_offset: expected %0d, got %0d", due.offset, ans_bus.word_offset);
            mismatches++;
          end
          if (ans_bus.result_address !== due.base) begin
            $error("result_address: expected %0h, got %0h", due.base, ans_bus.result_address);
            mismatches++;
          end
          case (due.status)
            ST_OK:      count_ok++;
            ST_OUTSIDE: count_outside++;
            ST_PROT:    count_prot++;
            default:    count_oom++;
          endcase
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        answers_due.push_back(predict_answer(cmd_bus.command, cmd_bus.address,
                                             cmd_bus.length, cmd_bus.flags));
      end
    end
    answers_due_count = answers_due.size();
  end

endmodule

// File: sim/testbench.sv
// Testbench top for the segment table protection unit: clock, reset, traffic and verdict.
`timescale 1ns / 1ps
module testbench;
  import stpu_pkg::*;

  // Command codes the block does not define; they must answer ok and change nothing.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // Permission masks built from the bit positions in the package.
  localparam logic [FLAGS_W-1:0] FL_R  = FLAGS_W'(1 << PERM_READ);
  localparam logic [FLAGS_W-1:0] FL_W  = FLAGS_W'(1 << PERM_WRITE);
  localparam logic [FLAGS_W-1:0] FL_M  = FLAGS_W'(1 << PERM_MAPPED);
  localparam logic [FLAGS_W-1:0] FL_RW = FL_R | FL_W;

  localparam int RESET_CYCLES    = 11;
  localparam int STALL_MAX       = 13;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_AT_FIRST   = 400;
  localparam int HOLD_AT_SECOND  = 1300;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 320;
  localparam int DRAIN_CYCLES    = 4;
  // Longest quiet stretch of a correct run is the receiver hold-off plus a few stalls.
  localparam int IDLE_LIMIT      = 4000;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;
  // While set, neither side inserts gaps, so the block runs at its full rate.
  logic no_gaps     = 1'b0;

  int mismatches;
  int answers_due_count;
  int count_ok, count_outside, count_prot, count_oom;
  int sent        = 0;
  int taken       = 0;
  int cfg_writes  = 0;
  int idle_cycles = 0;

  // Each phase has its own command mix: early ones fill the table to overflow,
  // later ones free slots so that reuse and refill both get exercised.
  int alloc_mix [PHASES] = '{40, 10, 30, 5, 50, 15};
  int free_mix  [PHASES] = '{5, 10, 20, 30, 5, 15};

  stpu_in_if  cmd_bus ();
  stpu_out_if ans_bus ();

  segment_table_protection_unit #(
    .MAX_SEGMENTS(64)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_bus),
    .out_ch      (ans_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  stpu_answer_check u_answer_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_bus           (cmd_bus),
    .ans_bus           (ans_bus),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatches        (mismatches),
    .answers_due_count (answers_due_count),
    .count_ok          (count_ok),
    .count_outside     (count_outside),
    .count_prot        (count_prot),
    .count_oom         (count_oom)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a run in which no beat moves on either channel for too long is hung.
  always @(posedge clk) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (ans_bus.valid && ans_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] word_address(int seg, int off);
    return seg * SEG_WORDS + off;
  endfunction

  // Offers one command beat. Entered and left at a falling edge; valid stays high
  // when the next command follows without a gap, so back-to-back beats happen.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len, input logic [FLAGS_W-1:0] perm);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.command <= op;
    cmd_bus.address <= addr;
    cmd_bus.length  <= len;
    cmd_bus.flags   <= perm;
    do @(posedge clk); while (!cmd_bus.ready);
    sent++;
    @(negedge clk);
  endtask

  // Stops offering commands and waits until every answer has come back, so the
  // block is idle and the register may be written.
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (answers_due_count != 0) @(negedge clk);
  endtask

  task automatic write_setting(input logic read_perm);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= read_perm;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  // One random command. Most addresses land in or just past the table, with
  // offsets and counts near the segment edges; a share is fully random noise.
  task automatic random_command(input int alloc_pct, input int free_pct);
    logic [CMD_W-1:0]   op;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [FLAGS_W-1:0] perm;
    int                 roll;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      op = CMD_ALLOC;
    end else if (roll < alloc_pct + free_pct) begin
      op = CMD_FREE;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30) op = CMD_READ;
      else if (roll < 60) op = CMD_WRITE;
      else if (roll < 75) op = CMD_RESIZE;
      else if (roll < 94) op = CMD_PERM;
      else if (roll < 97) op = CMD_SPARE_6;
      else op = CMD_SPARE_7;
    end

    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      addr = $urandom;
    end else begin
      addr[ADDR_W-1:OFF_W] = IDX_W'($urandom_range(0, 66));
      roll = $urandom_range(0, 99);
      if (roll < 60) addr[OFF_W-1:0] = OFF_W'($urandom_range(0, 40));
      else if (roll < 80) addr[OFF_W-1:0] = OFF_W'($urandom_range(SEG_WORDS - 40, SEG_WORDS - 1));
      else addr[OFF_W-1:0] = OFF_W'($urandom_range(0, SEG_WORDS - 1));
    end

    // Sizes and counts straddle the segment size, including just above it.
    roll = $urandom_range(0, 99);
    if (roll < 55) len = $urandom_range(0, 40);
    else if (roll < 75) len = $urandom_range(SEG_WORDS - 40, SEG_WORDS);
    else if (roll < 85) len = $urandom_range(SEG_WORDS + 1, SEG_WORDS + 8);
    else len = $urandom;

    // Permission changes are mostly legal so that segments actually change mode.
    if (op == CMD_PERM && $urandom_range(0, 3) != 0) begin
      perm = $urandom_range(0, 1) ? FL_RW : FL_R;
    end else begin
      perm = FLAGS_W'($urandom_range(0, 7));
    end
    send_command(op, addr, len, perm);
  endtask

  // Result side: draws a stall per beat, and twice holds off for a long stretch
  // while the sender keeps offering, so the block fills and backs up its input.
  initial begin : result_sink
    int hold;
    ans_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND) begin
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (hold > 0) begin
        ans_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      ans_bus.ready <= 1'b1;
      do @(posedge clk); while (!ans_bus.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    cmd_bus.valid   = 1'b0;
    cmd_bus.command = CMD_READ;
    cmd_bus.address = '0;
    cmd_bus.length  = '0;
    cmd_bus.flags   = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    write_setting(1'b0);

    // Directed part, read permission not required. An empty table rejects
    // everything as outside memory.
    send_command(CMD_READ, word_address(0, 0), 1, FL_R);
    send_command(CMD_FREE, word_address(0, 0), 0, '0);
    send_command(CMD_RESIZE, word_address(0, 0), 8, FL_RW);
    // Allocation with a size above one segment is out of memory.
    send_command(CMD_ALLOC, '0, SEG_WORDS + 1, FL_RW);
    send_command(CMD_ALLOC, '0, 32'hFFFF_FFFF, 3'b111);
    // Segments 0 to 4: full size, empty, mapped, no write, write without read.
    send_command(CMD_ALLOC, '0, SEG_WORDS, FL_RW);
    send_command(CMD_ALLOC, '0, 0, FL_R);
    send_command(CMD_ALLOC, '0, 16, FL_M | FL_RW);
    send_command(CMD_ALLOC, '0, 100, '0);
    send_command(CMD_ALLOC, '0, 4, FL_W);
    // Access boundaries: the whole segment, a run past the end, a zero count
    // at the last word, a huge count, and any access to a size-zero segment.
    send_command(CMD_READ, word_address(0, 0), SEG_WORDS, FL_R);
    send_command(CMD_WRITE, word_address(0, SEG_WORDS - 1), 2, FL_W);
    send_command(CMD_READ, word_address(0, SEG_WORDS - 1), 0, FL_R);
    send_command(CMD_READ, word_address(0, 0), 32'hFFFF_FFFF, FL_R);
    send_command(CMD_READ, word_address(1, 0), 0, FL_R);
    send_command(CMD_WRITE, word_address(3, 5), 1, FL_W);
    send_command(CMD_READ, word_address(3, 5), 1, FL_R);
    // Resize: mapped and read-only segments refuse, a legal one echoes the
    // address, and an oversized request is out of memory before anything else.
    send_command(CMD_RESIZE, word_address(2, 0), 8, '0);
    send_command(CMD_RESIZE, word_address(3, 0), 8, '0);
    send_command(CMD_RESIZE, word_address(0, 7), 10, '0);
    send_command(CMD_RESIZE, word_address(0, 0), SEG_WORDS + 1, '0);
    // Permission changes: mapped segment, mapped bit requested, read missing, legal.
    send_command(CMD_PERM, word_address(2, 0), 0, FL_R);
    send_command(CMD_PERM, word_address(0, 0), 0, FL_M | FL_R);
    send_command(CMD_PERM, word_address(0, 0), 0, FL_W);
    send_command(CMD_PERM, word_address(3, 0), 0, FL_R);
    // Free twice, then the freed slot is handed out again.
    send_command(CMD_FREE, word_address(1, 0), 0, '0);
    send_command(CMD_FREE, word_address(1, 0), 0, '0);
    send_command(CMD_ALLOC, '0, 1, FL_RW);
    // An undefined command and an index far past the table.
    send_command(CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
    send_command(CMD_READ, 32'hFFFF_F000, 1, FL_R);

    // With read permission required, a write-only segment faults.
    drain();
    write_setting(1'b1);
    send_command(CMD_WRITE, word_address(4, 0), 1, FL_W);
    send_command(CMD_READ, word_address(3, 0), 1, FL_R);

    // Random part: alternate the register and the command mix per phase, and
    // run some phases without any gaps on either side.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_setting(p % 2 == 0);
      no_gaps = (p == 2 || p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_command(alloc_mix[p], free_mix[p]);
      end
    end

    drain();
    no_gaps = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d commands under %0d register writes; %0d answers checked.",
             sent, cfg_writes, count_ok + count_outside + count_prot + count_oom);
    $display("Answers by status: ok %0d, outside %0d, protection %0d, out of memory %0d.",
             count_ok, count_outside, count_prot, count_oom);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: segment_table_protection_unit.f
src/stpu_pkg.sv
src/stpu_in_if.sv
src/stpu_out_if.sv
src/stpu_ram.sv
src/stpu_alloc.sv
src/segment_table_protection_unit.sv
sim/stpu_answer_check.sv
sim/testbench.sv
